// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a property.
`define CHK_IMPL(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
`endif

// ----- hdl/rtn_pkg.sv -----
// ---------------------------------------------------------------------------
// rtn_pkg: shared types for the nearest ray/triangle hit block
// Item structs, register indexes and width constants.
// ---------------------------------------------------------------------------
`default_nettype none
package rtn_pkg;
	localparam int unsigned MAX_TRIANGLES = 65536;
	localparam int unsigned POS_W = $clog2(MAX_TRIANGLES + 1);
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0, REG_ORIGIN_Y = 3'd1, REG_ORIGIN_Z = 3'd2,
		REG_DIR_X = 3'd3, REG_DIR_Y = 3'd4, REG_DIR_Z = 3'd5,
		REG_MAX_DIST = 3'd6, REG_DET_THR = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] v0_x;
		logic signed [31:0] v0_y;
		logic signed [31:0] v0_z;
		logic signed [31:0] v1_x;
		logic signed [31:0] v1_y;
		logic signed [31:0] v1_z;
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
		logic               last_triangle;
	} tri_item_t;

	typedef struct packed {
		logic               hit;
		logic [30:0]        distance;
		logic [15:0]        triangle_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} hit_item_t;
endpackage
`default_nettype wire

// ----- hdl/ray_triangle_nearest_hit.sv -----
// ---------------------------------------------------------------------------
// ray_triangle_nearest_hit: nearest Moller-Trumbore hit of one ray
// Q16.16 fixed-point triangle stream against a configured ray.
// ---------------------------------------------------------------------------
// Each triangle item is worked through before the next is accepted: a
// sequencer drives a single 32x32 multiplier and accumulator through the
// cross and dot products (one product per cycle between the divisions, 24
// in all, after the edge differences), and a radix-2 divider produces each
// of the three quotients (48 quotient bits plus setup and sign fix). A
// rejected triangle leaves early: on a near-zero determinant, when u falls
// outside, or when v does; a triangle beyond the stream limit skips the
// products. in_ready is low while a triangle is at work. The last triangle
// of a query adds three more products for the hit point and then loads the
// output register, where the result item sits until taken; the next
// triangle is accepted while it waits.
// Configuration is taken at any cycle the write enable is high.
`default_nettype none
module ray_triangle_nearest_hit import rtn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tri_item_t         in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hit_item_t              out_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_MUL, ST_DIVA, ST_DIV, ST_DIVF, ST_CHK, ST_PT, ST_OUT
	} state_t;

	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	function automatic logic signed [31:0] sat(input logic signed [63:0] x);
		if (x > SMAX) return 32'sh7fffffff;
		if (x < SMIN) return 32'sh80000000;
		return x[31:0];
	endfunction

	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic [30:0]        maxd_q, thr_q;
	logic [31:0]        best_q;
	logic               seen_q;
	logic [15:0]        bidx_q;
	logic [POS_W-1:0]   pos_q;

	// working vectors: 0 v0,1 e1,2 e2,3 s,4 p,5 q
	logic signed [31:0] vec_q [6][3];
	logic signed [31:0] v1_q [3], v2_q [3];
	logic               last_q, tst_q;
	logic signed [31:0] det_q, u_q;
	state_t             st_q;
	logic [5:0]         step_q;
	logic signed [63:0] acc_q;
	// divider
	logic [63:0]        rem_q;
	logic [47:0]        num_q;
	logic [31:0]        dmag_q;
	logic [48:0]        quo_q;
	logic               neg_q;
	logic [1:0]         which_q;
	logic [5:0]         dcnt_q;
	logic signed [31:0] pt_q [3];

	// product schedule: each step multiplies a by b, adds (or subtracts) and
	// at the end of a group saturates into a destination
	logic signed [31:0] ma, mb;
	logic               msub, mend;
	logic [2:0]         mdst; // 0..2 p,3 det,4 numerator (sp, dq, e2q),5..7 q
	logic [2:0]         mdk;
	always_comb begin
		ma = '0; mb = '0; msub = 1'b0; mend = 1'b0; mdst = '0; mdk = '0;
		unique case (step_q)
			6'd0: begin ma = dir_q[1]; mb = vec_q[2][2]; end
			6'd1: begin ma = dir_q[2]; mb = vec_q[2][1]; msub = 1'b1; mend = 1'b1; mdst = 3'd0; end
			6'd2: begin ma = dir_q[2]; mb = vec_q[2][0]; end
			6'd3: begin ma = dir_q[0]; mb = vec_q[2][2]; msub = 1'b1; mend = 1'b1; mdst = 3'd1; end
			6'd4: begin ma = dir_q[0]; mb = vec_q[2][1]; end
			6'd5: begin ma = dir_q[1]; mb = vec_q[2][0]; msub = 1'b1; mend = 1'b1; mdst = 3'd2; end
			6'd6: begin ma = vec_q[1][0]; mb = vec_q[4][0]; end
			6'd7: begin ma = vec_q[1][1]; mb = vec_q[4][1]; end
			6'd8: begin ma = vec_q[1][2]; mb = vec_q[4][2]; mend = 1'b1; mdst = 3'd3; end
			6'd9: begin ma = vec_q[3][0]; mb = vec_q[4][0]; end
			6'd10: begin ma = vec_q[3][1]; mb = vec_q[4][1]; end
			6'd11: begin ma = vec_q[3][2]; mb = vec_q[4][2]; mend = 1'b1; mdst = 3'd4; end
			6'd12: begin ma = vec_q[3][1]; mb = vec_q[1][2]; end
			6'd13: begin ma = vec_q[3][2]; mb = vec_q[1][1]; msub = 1'b1; mend = 1'b1; mdst = 3'd5; end
			6'd14: begin ma = vec_q[3][2]; mb = vec_q[1][0]; end
			6'd15: begin ma = vec_q[3][0]; mb = vec_q[1][2]; msub = 1'b1; mend = 1'b1; mdst = 3'd6; end
			6'd16: begin ma = vec_q[3][0]; mb = vec_q[1][1]; end
			6'd17: begin ma = vec_q[3][1]; mb = vec_q[1][0]; msub = 1'b1; mend = 1'b1; mdst = 3'd7; end
			6'd18: begin ma = dir_q[0]; mb = vec_q[5][0]; end
			6'd19: begin ma = dir_q[1]; mb = vec_q[5][1]; end
			6'd20: begin ma = dir_q[2]; mb = vec_q[5][2]; mend = 1'b1; mdst = 3'd4; end
			6'd21: begin ma = vec_q[2][0]; mb = vec_q[5][0]; end
			6'd22: begin ma = vec_q[2][1]; mb = vec_q[5][1]; end
			6'd23: begin ma = vec_q[2][2]; mb = vec_q[5][2]; mend = 1'b1; mdst = 3'd4; end
			6'd24: begin ma = dir_q[0]; mb = best_q; mdk = 3'd0; end
			6'd25: begin ma = dir_q[1]; mb = best_q; mdk = 3'd1; end
			6'd26: begin ma = dir_q[2]; mb = best_q; mdk = 3'd2; end
			default: ;
		endcase
	end

	// shared multiplier with floor shift
	logic signed [63:0] prod, prod_sh, acc_n;
	assign prod    = ma * mb;
	assign prod_sh = prod >>> 16;
	assign acc_n   = msub ? acc_q - prod_sh : acc_q + prod_sh;

	logic signed [32:0] adet;
	assign adet = det_q[31] ? -{det_q[31], det_q} : {det_q[31], det_q};

	// divider step: restoring, one quotient bit a cycle
	logic [63:0] rsh;
	assign rsh = {rem_q[62:0], num_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
			dir_q[0] <= 32'sd65536; dir_q[1] <= '0; dir_q[2] <= '0;
			maxd_q <= 31'h7fffffff; thr_q <= 31'd1;
			best_q <= 32'h7fffffff; seen_q <= 1'b0; bidx_q <= '0; pos_q <= '0;
			st_q <= ST_IDLE; step_q <= '0; out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ORIGIN_X: org_q[0] <= cfg_data;
					REG_ORIGIN_Y: org_q[1] <= cfg_data;
					REG_ORIGIN_Z: org_q[2] <= cfg_data;
					REG_DIR_X:    dir_q[0] <= cfg_data;
					REG_DIR_Y:    dir_q[1] <= cfg_data;
					REG_DIR_Z:    dir_q[2] <= cfg_data;
					REG_MAX_DIST: begin
						maxd_q <= cfg_data[30:0];
						if (pos_q == '0) best_q <= {1'b0, cfg_data[30:0]};
					end
					REG_DET_THR:  thr_q <= cfg_data[30:0];
				endcase
			end
			unique case (st_q)
				ST_IDLE: if (in_valid && in_ready) begin
					vec_q[0][0] <= in_data.v0_x; vec_q[0][1] <= in_data.v0_y;
					vec_q[0][2] <= in_data.v0_z;
					v1_q[0] <= in_data.v1_x; v1_q[1] <= in_data.v1_y; v1_q[2] <= in_data.v1_z;
					v2_q[0] <= in_data.v2_x; v2_q[1] <= in_data.v2_y; v2_q[2] <= in_data.v2_z;
					last_q <= in_data.last_triangle;
					tst_q <= (pos_q < POS_W'(MAX_TRIANGLES));
					st_q <= ST_DIFF;
				end
				ST_DIFF: begin
					for (int k = 0; k < 3; k++) begin
						vec_q[1][k] <= sat(64'(v1_q[k]) - 64'(vec_q[0][k]));
						vec_q[2][k] <= sat(64'(v2_q[k]) - 64'(vec_q[0][k]));
						vec_q[3][k] <= sat(64'(org_q[k]) - 64'(vec_q[0][k]));
					end
					acc_q <= '0; step_q <= '0;
					st_q <= tst_q ? ST_MUL : ST_CHK;
				end
				ST_MUL: begin
					acc_q <= mend ? '0 : acc_n;
					step_q <= step_q + 6'd1;
					if (mend) begin
						unique case (mdst)
							3'd0, 3'd1, 3'd2: vec_q[4][mdst[1:0]] <= sat(acc_n);
							3'd3: det_q <= sat(acc_n);
							3'd4: begin
								num_q <= {sat(acc_n), 16'h0};
								st_q <= ST_DIVA;
							end
							default: vec_q[5][2'(mdst - 3'd5)] <= sat(acc_n);
						endcase
						if (mdst == 3'd3 && (sat(acc_n) == 0 ||
						    (sat(acc_n) < 0 ? -64'(sat(acc_n)) : 64'(sat(acc_n)))
						    < 64'(thr_q))) st_q <= ST_CHK;
						if (mdst == 3'd4) which_q <= (step_q == 6'd11) ? 2'd0 :
							(step_q == 6'd20) ? 2'd1 : 2'd2;
					end
				end
				ST_DIVA: begin
					neg_q <= num_q[47] ^ det_q[31];
					num_q <= num_q[47] ? -num_q : num_q;
					dmag_q <= adet[31:0];
					rem_q <= '0; quo_q <= '0; dcnt_q <= 6'd47;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rsh >= 64'(dmag_q)) begin
						rem_q <= rsh - 64'(dmag_q); quo_q <= {quo_q[47:0], 1'b1};
					end else begin
						rem_q <= rsh; quo_q <= {quo_q[47:0], 1'b0};
					end
					num_q <= {num_q[46:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == '0) st_q <= ST_DIVF;
				end
				ST_DIVF: begin
					logic signed [31:0] r;
					r = sat(neg_q ? -64'(quo_q) : 64'(quo_q));
					st_q <= ST_MUL;
					unique case (which_q)
						2'd0: begin
							u_q <= r;
							if (r < 0 || r > 32'sd65536) st_q <= ST_CHK;
						end
						2'd1: begin
							if (r < 0 || 33'(signed'(r)) + 33'(signed'(u_q)) > 33'sd65536)
								st_q <= ST_CHK;
						end
						default: begin
							st_q <= ST_CHK;
							if (r > 0 && r < signed'(best_q)) begin
								best_q <= r; bidx_q <= pos_q[15:0]; seen_q <= 1'b1;
							end
						end
					endcase
				end
				ST_CHK: begin
					if (tst_q) pos_q <= pos_q + POS_W'(1);
					if (last_q) begin
						step_q <= 6'd24; st_q <= ST_PT;
					end else st_q <= ST_IDLE;
				end
				ST_PT: begin
					pt_q[mdk[1:0]] <= seen_q ? sat(64'(org_q[mdk[1:0]]) + prod_sh) : '0;
					step_q <= step_q + 6'd1;
					if (step_q == 6'd26) st_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					out_data.hit <= seen_q;
					out_data.distance <= best_q[30:0];
					out_data.triangle_index <= seen_q ? bidx_q : '0;
					out_data.point_x <= pt_q[0];
					out_data.point_y <= pt_q[1];
					out_data.point_z <= pt_q[2];
					best_q <= {1'b0, maxd_q}; seen_q <= 1'b0; bidx_q <= '0; pos_q <= '0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (st_q == ST_IDLE);
endmodule
`default_nettype wire

// ----- hdl/rtn_checker.sv -----
// ---------------------------------------------------------------------------
// rtn_checker: port-level checks for the nearest hit block
// Handshake and result consistency seen at the ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rtn_checker import rtn_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire hit_item_t out_data
);
	`CHK_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 out_valid && $stable(out_data), "result item dropped or changed while stalled")
	`CHK_IMPL(a_busy, clk, arst_n, in_valid && in_ready, ##1 !in_ready, "item accepted while busy")
	`CHK_IMPL(a_miss, clk, arst_n, out_valid && !out_data.hit, out_data.triangle_index == 16'd0 && out_data.point_x == 0, "miss carries index or point")
endmodule
bind ray_triangle_nearest_hit rtn_checker u_rtn_checker (.*);
`default_nettype wire

// ----- test/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: nearest ray/triangle hit, self-checking
// Streams triangle queries at the block under several ray settings, predicts
// each query's nearest hit in Q16.16 and checks every result item field by
// field.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
	import rtn_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	tri_item_t in_data;
	logic out_valid;
	logic out_ready;
	hit_item_t out_data;

	ray_triangle_nearest_hit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Ray copy used by the predictor
	longint ray_org[3];
	longint ray_dir[3];
	longint far_limit;
	longint det_min;
	// Running query state
	longint near_t;
	bit near_found;
	longint near_idx;
	longint tri_pos;

	hit_item_t hits_due[$];
	int errors;
	int idle_cycles;
	bit run_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Exact product, shifted right by 16 rounding toward minus infinity
	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> 16;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		return clamp32((n * 65536) / d);
	endfunction

	function automatic longint dot_q(longint a[3], longint b[3]);
		return clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
	endfunction

	task automatic cross_q(input longint a[3], input longint b[3], output longint r[3]);
		r[0] = clamp32(qmul(a[1], b[2]) - qmul(a[2], b[1]));
		r[1] = clamp32(qmul(a[2], b[0]) - qmul(a[0], b[2]));
		r[2] = clamp32(qmul(a[0], b[1]) - qmul(a[1], b[0]));
	endtask

	function automatic void clear_query();
		near_t = far_limit;
		near_found = 0;
		near_idx = 0;
		tri_pos = 0;
	endfunction

	// Moller-Trumbore on one triangle; keep it if strictly nearer
	task automatic test_triangle(input tri_item_t tr);
		longint v0[3], e1[3], e2[3], s[3], p[3], q[3];
		longint det, adet, u, v, t;
		v0[0] = tr.v0_x; v0[1] = tr.v0_y; v0[2] = tr.v0_z;
		e1[0] = clamp32(longint'(tr.v1_x) - v0[0]);
		e1[1] = clamp32(longint'(tr.v1_y) - v0[1]);
		e1[2] = clamp32(longint'(tr.v1_z) - v0[2]);
		e2[0] = clamp32(longint'(tr.v2_x) - v0[0]);
		e2[1] = clamp32(longint'(tr.v2_y) - v0[1]);
		e2[2] = clamp32(longint'(tr.v2_z) - v0[2]);
		for (int k = 0; k < 3; k++) s[k] = clamp32(ray_org[k] - v0[k]);
		cross_q(ray_dir, e2, p);
		det = dot_q(e1, p);
		adet = det < 0 ? -det : det;
		if (det == 0 || adet < det_min) return;
		u = qdiv(dot_q(s, p), det);
		if (u < 0 || u > 65536) return;
		cross_q(s, e1, q);
		v = qdiv(dot_q(ray_dir, q), det);
		if (v < 0 || u + v > 65536) return;
		t = qdiv(dot_q(e2, q), det);
		if (t <= 0 || t >= near_t) return;
		near_t = t;
		near_idx = tri_pos;
		near_found = 1;
	endtask

	task automatic predict_triangle(input tri_item_t tr);
		hit_item_t h;
		if (tri_pos < MAX_TRIANGLES) begin
			test_triangle(tr);
			tri_pos++;
		end
		if (!tr.last_triangle) return;
		h.hit = near_found;
		h.distance = near_t[30:0];
		h.triangle_index = near_found ? near_idx[15:0] : 16'd0;
		h.point_x = 32'(near_found ? clamp32(ray_org[0] + qmul(ray_dir[0], near_t)) : 0);
		h.point_y = 32'(near_found ? clamp32(ray_org[1] + qmul(ray_dir[1], near_t)) : 0);
		h.point_z = 32'(near_found ? clamp32(ray_org[2] + qmul(ray_dir[2], near_t)) : 0);
		hits_due = {hits_due, h};
		clear_query();
	endtask

	// Write one register; only called while the block is idle
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_org[idx] = longint'(signed'(val));
			REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - 3] = longint'(signed'(val));
			REG_MAX_DIST: begin
				far_limit = val[30:0];
				if (tri_pos == 0) near_t = far_limit;
			end
			REG_DET_THR: det_min = val[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_ray(input longint ox, oy, oz, dx, dy, dz, fmax, thr);
		write_reg(REG_ORIGIN_X, ox[31:0]);
		write_reg(REG_ORIGIN_Y, oy[31:0]);
		write_reg(REG_ORIGIN_Z, oz[31:0]);
		write_reg(REG_DIR_X, dx[31:0]);
		write_reg(REG_DIR_Y, dy[31:0]);
		write_reg(REG_DIR_Z, dz[31:0]);
		write_reg(REG_MAX_DIST, fmax[31:0]);
		write_reg(REG_DET_THR, thr[31:0]);
	endtask

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Send one item, holding valid and payload until it is taken
	task automatic send_triangle(input tri_item_t tr);
		int gap;
		gap = short_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= tr;
		do @(posedge clk); while (!in_ready);
		predict_triangle(tr);
	endtask

	// Hold off until every expected result has arrived, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (hits_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// Triangle that straddles the x axis ahead of the origin, random size
	function automatic tri_item_t aimed_triangle(bit last);
		tri_item_t tr;
		int reach, r;
		reach = $urandom_range(1, 40) * 65536 + $urandom_range(0, 65535);
		r = $urandom_range(1, 8) * 65536;
		tr.v0_x = reach + rnd_coord(65536);
		tr.v0_y = -r + rnd_coord(20000);
		tr.v0_z = -r + rnd_coord(20000);
		tr.v1_x = reach + rnd_coord(65536);
		tr.v1_y = r + rnd_coord(20000);
		tr.v1_z = -r + rnd_coord(20000);
		tr.v2_x = reach + rnd_coord(65536);
		tr.v2_y = rnd_coord(20000);
		tr.v2_z = r + rnd_coord(20000);
		tr.last_triangle = last;
		return tr;
	endfunction

	function automatic tri_item_t wild_triangle(bit last);
		tri_item_t tr;
		tr = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, 1'b0};
		tr.last_triangle = last;
		return tr;
	endfunction

	function automatic tri_item_t flat_triangle(int x, int y0, int y1, int z0, int z1, bit last);
		tri_item_t tr;
		tr.v0_x = x; tr.v0_y = y0; tr.v0_z = z0;
		tr.v1_x = x; tr.v1_y = y1; tr.v1_z = z0;
		tr.v2_x = x; tr.v2_y = y0; tr.v2_z = z1;
		tr.last_triangle = last;
		return tr;
	endfunction

	// Directed: reset ray, nearest selection, miss, parallel, extremes, zero threshold, tiny max distance, extreme ray
	task automatic test_directed();
		tri_item_t tr;
		// Nearest of three, hit in the middle of the stream
		send_triangle(flat_triangle(5 << 16, -65536, 65536, -65536, 65536, 0));
		send_triangle(flat_triangle(2 << 16, -65536, 65536, -65536, 65536, 0));
		send_triangle(flat_triangle(3 << 16, -65536, 65536, -65536, 65536, 1));
		// Miss: behind the origin, then off to the side
		send_triangle(flat_triangle(-(3 << 16), -65536, 65536, -65536, 65536, 0));
		send_triangle(flat_triangle(4 << 16, 65536, 3 << 16, 65536, 3 << 16, 1));
		// Edge on: zero determinant
		tr = flat_triangle(0, 0, 0, 0, 0, 0);
		tr.v1_x = 10 << 16; tr.v2_x = 20 << 16; tr.v2_y = 65536;
		send_triangle(tr);
		tr.last_triangle = 1;
		send_triangle(tr);
		// Extremes of the fields
		tr = {{9{32'h8000_0000}}, 1'b0};
		send_triangle(tr);
		tr = {{9{32'h7fff_ffff}}, 1'b1};
		send_triangle(tr);
		send_triangle(wild_triangle(1));
		tr = {{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h0000_0000}}, 1'b1};
		send_triangle(tr);
		drain();
		// Zero threshold still rejects a zero determinant; tiny max distance
		set_ray(0, 0, 0, 65536, 0, 0, 2 << 16, 0);
		tr = flat_triangle(0, 0, 0, 0, 0, 1);
		tr.v1_x = 10 << 16; tr.v2_x = 20 << 16; tr.v2_y = 65536;
		send_triangle(tr);
		send_triangle(flat_triangle(3 << 16, -65536, 65536, -65536, 65536, 0));
		send_triangle(flat_triangle(1 << 16, -65536, 65536, -65536, 65536, 1));
		send_triangle(flat_triangle(2 << 16, -65536, 65536, -65536, 65536, 1));
		drain();
		// Extreme ray registers
		set_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 0, 32'h7fff_ffff);
		send_triangle(wild_triangle(0));
		send_triangle(wild_triangle(1));
		drain();
		set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_triangle(wild_triangle(1));
		send_triangle(flat_triangle(5 << 16, -65536, 65536, -65536, 65536, 1));
		drain();
	endtask

	// Max distance written mid-query only applies from the next query
	task automatic test_max_distance_write();
		set_ray(0, 0, 0, 65536, 0, 0, 32'h7fff_ffff, 1);
		send_triangle(flat_triangle(8 << 16, -65536, 65536, -65536, 65536, 0));
		drain();
		write_reg(REG_MAX_DIST, 4 << 16);
		send_triangle(flat_triangle(6 << 16, -65536, 65536, -65536, 65536, 1));
		send_triangle(flat_triangle(6 << 16, -65536, 65536, -65536, 65536, 1));
		drain();
	endtask

	// Random queries, mostly aimed at the ray, under several ray settings
	task automatic test_random_queries();
		int sent, qlen;
		sent = 0;
		while (sent < 1200) begin
			if ($urandom_range(0, 3) == 0)
				set_ray(rnd_coord(65536), rnd_coord(65536), rnd_coord(65536),
					65536 + rnd_coord(3000), rnd_coord(3000), rnd_coord(3000),
					$urandom_range(0, 3) == 0 ? $urandom_range(65536, 30 << 16)
						: 32'h7fff_ffff,
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 20)
						: $urandom_range(0, 2));
			qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 6);
			for (int i = 0; i < qlen; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_triangle(wild_triangle(i == qlen - 1));
				else
					send_triangle(aimed_triangle(i == qlen - 1));
				sent++;
			end
			drain();
		end
	endtask

	// Check each result item against the oldest expectation
	always @(posedge clk) begin
		hit_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (hits_due.size() == 0) begin
				$display("%0t: unexpected result item %p", $time, out_data);
				errors++;
			end else begin
				want = hits_due.pop_front();
				if (out_data.hit !== want.hit) begin
					$display("%0t: hit exp %0d got %0d", $time, want.hit, out_data.hit);
					errors++;
				end
				if (out_data.distance !== want.distance) begin
					$display("%0t: distance exp %h got %h", $time, want.distance,
						out_data.distance);
					errors++;
				end
				if (out_data.triangle_index !== want.triangle_index) begin
					$display("%0t: index exp %0d got %0d", $time, want.triangle_index,
						out_data.triangle_index);
					errors++;
				end
				if (out_data.point_x !== want.point_x) begin
					$display("%0t: point_x exp %h got %h", $time, want.point_x,
						out_data.point_x);
					errors++;
				end
				if (out_data.point_y !== want.point_y) begin
					$display("%0t: point_y exp %h got %h", $time, want.point_y,
						out_data.point_y);
					errors++;
				end
				if (out_data.point_z !== want.point_z) begin
					$display("%0t: point_z exp %h got %h", $time, want.point_z,
						out_data.point_z);
					errors++;
				end
			end
		end
	end

	// Stall the result side at random, with runs of no stalling
	always @(posedge clk) begin
		if ($urandom_range(0, 3) == 0)
			out_ready <= 1'b1;
		else if ($urandom_range(0, 40) == 0)
			out_ready <= 1'b0;
		else if ($urandom_range(0, 2) == 0)
			out_ready <= ~out_ready;
	end

	// Watchdog: end the run if nothing is accepted for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || run_done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		run_done = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		ray_org = '{0, 0, 0};
		ray_dir = '{65536, 0, 0};
		far_limit = 64'h7fff_ffff;
		det_min = 1;
		clear_query();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_max_distance_write();
		test_random_queries();
		drain();
		run_done = 1;
		if (errors == 0 && hits_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
